// ----- sv/lbfg_pkg.sv -----
// lbfg_pkg: shared types, codes, tables and helper functions of the breathing fader
`timescale 1ns / 1ps

package lbfg_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_t;

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  localparam logic CFG_TWINKLE = 1'b0;
  localparam logic CFG_FLICKER = 1'b1;

  localparam logic [7:0] TWINKLE_RESET = 8'd20;
  localparam logic       FLICKER_RESET = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // 0.8 in q0.16 shifted up by 15, and 0.2 in q0.16
  localparam logic [31:0]        FACTOR_BASE  = 32'd1717993472;
  localparam logic signed [15:0] FACTOR_SWING = 16'sd13107;

  typedef struct packed {
    logic       clear;
    logic       set_target;
    logic       frame;
    logic       start;
    logic       issue;
    logic [1:0] ch;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic pix_ok;
    logic calc_done;
    logic out_free;
  } dp_stat_t;

  localparam logic [15:0] SINE_QUARTER [33] = '{
        16'd0,  16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,  16'd9512, 16'd11039,
    16'd12539, 16'd14010, 16'd15446, 16'd16846, 16'd18204, 16'd19519, 16'd20787, 16'd22005,
    16'd23170, 16'd24279, 16'd25329, 16'd26319, 16'd27245, 16'd28105, 16'd28898, 16'd29621,
    16'd30273, 16'd30852, 16'd31356, 16'd31785, 16'd32137, 16'd32412, 16'd32609, 16'd32728,
    16'd32767
  };

  localparam logic [7:0] GAMMA_ROM [256] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,  8'd10,
     8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
     8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
     8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
     8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
     8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
     8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
     8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
     8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
     8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
     8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
     8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
     8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
     8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99, 8'd101,
    8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
    8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
    8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
    8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
    8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
    8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
    8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
    8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
  };

  function automatic logic [9:0] phase_step(input logic [1:0] ch);
    logic [9:0] step;
    unique case (ch)
      CH_RED:   step = 10'd313;
      CH_GREEN: step = 10'd522;
      CH_BLUE:  step = 10'd417;
      default:  step = 10'd0;
    endcase
    return step;
  endfunction

  // q1.15 sine, 128 steps per turn, quarter-wave mirrored
  function automatic logic signed [15:0] sine_q15(input logic [15:0] phase);
    logic [6:0]  idx;
    logic [5:0]  j;
    logic [15:0] mag;
    idx = phase[15:9];
    j = {1'b0, idx[4:0]};
    if (idx[5]) begin
      j = 6'd32 - j;
    end
    mag = SINE_QUARTER[j];
    return idx[6] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ----- sv/lbfg_ctrl.sv -----
// lbfg_ctrl: controller state machine sequencing clear, item decode, channel issue and finish
`timescale 1ns / 1ps

module lbfg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  lbfg_pkg::dp_stat_t stat,
  output lbfg_pkg::dp_cmd_t  cmd
);

  lbfg_pkg::state_t state, state_next;
  logic [1:0] ch_cnt, ch_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lbfg_pkg::ST_CLEAR;
      ch_cnt <= lbfg_pkg::CH_RED;
    end else begin
      state  <= state_next;
      ch_cnt <= ch_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    ch_cnt_next    = ch_cnt;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.ch         = ch_cnt;
    unique case (state)
      lbfg_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = lbfg_pkg::ST_IDLE;
        end
      end
      lbfg_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        ch_cnt_next = lbfg_pkg::CH_RED;
        if (in_valid) begin
          case (kind)
            lbfg_pkg::KIND_SET: begin
              cmd.set_target = stat.pix_ok;
            end
            lbfg_pkg::KIND_FRAME: begin
              cmd.frame = 1'b1;
            end
            lbfg_pkg::KIND_UPDATE: begin
              if (stat.pix_ok) begin
                cmd.start  = 1'b1;
                state_next = lbfg_pkg::ST_ISSUE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      lbfg_pkg::ST_ISSUE: begin
        cmd.issue   = 1'b1;
        ch_cnt_next = ch_cnt + 2'd1;
        if (ch_cnt == lbfg_pkg::CH_BLUE) begin
          state_next = lbfg_pkg::ST_FINISH;
        end
      end
      lbfg_pkg::ST_FINISH: begin
        if (stat.calc_done && stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = lbfg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbfg_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- sv/lbfg_dp.sv -----
// lbfg_dp: datapath with pixel stores, tick, flicker remainder unit, breathing pipeline, output
`timescale 1ns / 1ps

module lbfg_dp #(
  parameter int PIXEL_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  lbfg_pkg::dp_cmd_t  cmd,
  output lbfg_pkg::dp_stat_t stat,
  input  logic [5:0]         pixel_index,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [15:0]        random_value,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_pixel,
  output logic [7:0]         gamma_red,
  output logic [7:0]         gamma_green,
  output logic [7:0]         gamma_blue
);

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [3:0] MOD_STEPS = 4'd8;

  // configuration
  logic [7:0] twinkle_rate;
  logic       flicker_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      twinkle_rate   <= lbfg_pkg::TWINKLE_RESET;
      flicker_enable <= lbfg_pkg::FLICKER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lbfg_pkg::CFG_TWINKLE: twinkle_rate   <= cfg_data;
        lbfg_pkg::CFG_FLICKER: flicker_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // frame tick
  logic [15:0] tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (cmd.frame) begin
      tick <= {1'b0, tick[14:0]} + 16'd1;
    end
  end

  // clearing pass address
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !stat.clear_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // pixel stores
  logic [23:0]   tgt_mem [PIXEL_COUNT];
  logic [23:0]   cur_mem [PIXEL_COUNT];
  logic [23:0]   tgt_rd;
  logic [23:0]   cur_rd;
  logic [AW-1:0] in_addr;
  logic [5:0]    pix_reg;
  logic [23:0]   new_color;

  assign in_addr = AW'(pixel_index);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tgt_mem[clr_addr] <= '0;
    end else if (cmd.set_target) begin
      tgt_mem[in_addr] <= {red, green, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      cur_mem[clr_addr] <= '0;
    end else if (cmd.finish) begin
      cur_mem[AW'(pix_reg)] <= new_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tgt_rd  <= tgt_mem[in_addr];
      cur_rd  <= cur_mem[in_addr];
      pix_reg <= pixel_index;
    end
  end

  // flicker remainder, two bits per cycle
  logic [15:0] rnd_sh;
  logic [9:0]  rem;
  logic [3:0]  mod_cnt;
  logic [9:0]  divisor;
  logic [10:0] r1;
  logic [10:0] r2;
  logic        mod_done;
  logic        flick;

  assign divisor  = {2'b00, twinkle_rate} + {1'b0, twinkle_rate, 1'b0};
  assign mod_done = (mod_cnt == MOD_STEPS);

  always_comb begin
    r1 = {rem, rnd_sh[15]};
    if (r1 >= {1'b0, divisor}) begin
      r1 = r1 - {1'b0, divisor};
    end
    r2 = {r1[9:0], rnd_sh[14]};
    if (r2 >= {1'b0, divisor}) begin
      r2 = r2 - {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= MOD_STEPS;
    end else if (cmd.start) begin
      mod_cnt <= '0;
    end else if (!mod_done) begin
      mod_cnt <= mod_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rnd_sh <= random_value;
      rem    <= '0;
    end else if (!mod_done) begin
      rnd_sh <= {rnd_sh[13:0], 2'b00};
      rem    <= r2[9:0];
    end
  end

  assign flick = flicker_enable && (twinkle_rate != 8'd0) && (rem == 10'd0);

  // breathing pipeline, one channel per stage
  logic               s1_v, s2_v, s3_v;
  logic [1:0]         s1_ch, s2_ch, s3_ch;
  logic [15:0]        s1_ph;
  logic signed [29:0] s2_sp;
  logic [23:0]        s3_tf;
  logic [7:0]         nv [3];
  logic [15:0]        base_pos;
  logic [25:0]        ph_prod;
  logic signed [31:0] sp_prod;
  logic [31:0]        num;
  logic [15:0]        factor;
  logic [7:0]         tgt_byte;
  logic [7:0]         cur_byte;
  logic [7:0]         scaled;
  logic [8:0]         diff;
  logic [8:0]         mag;
  logic [3:0]         q;
  logic signed [9:0]  v;
  logic [7:0]         v_clamp;

  assign base_pos = tick + {10'b0, pix_reg};
  assign ph_prod  = base_pos * lbfg_pkg::phase_step(cmd.ch);
  assign sp_prod  = lbfg_pkg::sine_q15(s1_ph) * lbfg_pkg::FACTOR_SWING;
  assign num      = lbfg_pkg::FACTOR_BASE + $unsigned(32'(s2_sp));
  assign factor   = num[30:15];

  always_comb begin
    case (s2_ch)
      lbfg_pkg::CH_RED:   tgt_byte = tgt_rd[23:16];
      lbfg_pkg::CH_GREEN: tgt_byte = tgt_rd[15:8];
      default:            tgt_byte = tgt_rd[7:0];
    endcase
    case (s3_ch)
      lbfg_pkg::CH_RED:   cur_byte = cur_rd[23:16];
      lbfg_pkg::CH_GREEN: cur_byte = cur_rd[15:8];
      default:            cur_byte = cur_rd[7:0];
    endcase
  end

  always_comb begin
    scaled = s3_tf[23:16];
    diff   = {1'b0, scaled} - {1'b0, cur_byte};
    mag    = diff[8] ? (9'd0 - diff) : diff;
    q      = mag[7:4];
    if (diff == 9'd0) begin
      v = $signed({2'b00, cur_byte});
    end else if (diff[8]) begin
      v = $signed({2'b00, cur_byte}) - 10'sd1 - $signed({6'b0, q});
    end else begin
      v = $signed({2'b00, cur_byte}) + 10'sd1 + $signed({6'b0, q});
    end
    if (v < 10'sd0) begin
      v_clamp = 8'd0;
    end else if (v > 10'sd255) begin
      v_clamp = 8'd255;
    end else begin
      v_clamp = v[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_ch <= cmd.ch;
    s1_ph <= ph_prod[15:0];
    s2_ch <= s1_ch;
    s2_sp <= 30'(sp_prod);
    s3_ch <= s2_ch;
    s3_tf <= tgt_byte * factor;
    if (s3_v) begin
      nv[s3_ch] <= v_clamp;
    end
  end

  // flicker and output register
  logic [7:0] fv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (flick) begin
        fv[i] = nv[i][7] ? 8'hFF : {nv[i][6:0], 1'b0};
      end else begin
        fv[i] = nv[i];
      end
    end
  end

  assign new_color = {fv[0], fv[1], fv[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pixel   <= pix_reg;
      gamma_red   <= lbfg_pkg::GAMMA_ROM[fv[0]];
      gamma_green <= lbfg_pkg::GAMMA_ROM[fv[1]];
      gamma_blue  <= lbfg_pkg::GAMMA_ROM[fv[2]];
    end
  end

  assign stat.clear_done = (clr_addr == AW'(PIXEL_COUNT - 1));
  assign stat.pix_ok     = (32'(pixel_index) < PIXEL_COUNT);
  assign stat.calc_done  = mod_done && !(s1_v || s2_v || s3_v);
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

// ----- sv/led_breathing_fader_gamma.sv -----
// led_breathing_fader_gamma: top level of the breathing led fader with gamma output
//
// Input channel (in_valid / in_stall) carries one item per transfer: set target,
// advance frame tick, or update pixel. Output channel (out_valid / out_stall)
// carries one gamma corrected color per update of an in-range pixel.
// Set target, frame and dropped items are taken while idle, with in_stall low.
// An update holds in_stall high until its result is loaded into the output
// register. The wait is set by the flicker remainder unit, which retires two
// dividend bits per cycle over the 16-bit random value, while the three color
// channels run through the phase, sine and scale multipliers one behind the
// other.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once.
// After reset a clearing pass zeroes both pixel stores, one entry a cycle,
// with in_stall high; config writes are still taken.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile, and a later update holds in its last
// step until the register is free.
`timescale 1ns / 1ps

module led_breathing_fader_gamma #(
  parameter int PIXEL_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [5:0]  pixel_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [15:0] random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_pixel,
  output logic [7:0]  gamma_red,
  output logic [7:0]  gamma_green,
  output logic [7:0]  gamma_blue,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  lbfg_pkg::dp_cmd_t  cmd;
  lbfg_pkg::dp_stat_t stat;

  lbfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbfg_dp #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pixel_index  (pixel_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .random_value (random_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .gamma_red    (gamma_red),
    .gamma_green  (gamma_green),
    .gamma_blue   (gamma_blue)
  );

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result loaded while output register still held");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.set_target, cmd.frame, cmd.start, cmd.issue, cmd.finish}))
    else $error("more than one datapath command at once");

  a_start_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (cmd.issue && cmd.ch == lbfg_pkg::CH_RED))
    else $error("update start not followed by red channel issue");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished update did not raise out_valid");

endmodule
